@@ hdl/rdg0_pkg.sv @@
`timescale 1ns / 1ps
package rdg0_pkg;

   // Fraction format of the Q1.24 input fields
   localparam int FRAC_BITS = 24;

   localparam int FIELD_W = 25;
   localparam int DIAM_W  = 16;
   localparam int OUT_W   = 48;
   localparam int Q_W     = 64;
   localparam int TERM_W  = Q_W + 5;

   localparam logic [FIELD_W-1:0] RESIDUAL_RESET = FIELD_W'(17);

   // Scaling of the mixture term x = num / dsum into Q34.30
   localparam int NUM_SH  = (FRAC_BITS <= 30) ? 30 - FRAC_BITS : 0;
   localparam int DSUM_SH = (FRAC_BITS > 30) ? FRAC_BITS - 30 : 0;
   localparam int PROD_W  = FIELD_W + DIAM_W;
   localparam int NUM_W   = PROD_W + 1 + NUM_SH;
   localparam int DSR_W   = DIAM_W + 1;
   localparam int DSUM_W  = DSR_W + DSUM_SH;

   // Pipelined divider: DIV_STEP quotient bits per stage
   localparam int DIV_STEP   = 4;
   localparam int DIV_W      = FIELD_W + 32 + FRAC_BITS;
   localparam int DIV_STAGES = (DIV_W + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_PAD    = DIV_STAGES * DIV_STEP;

   localparam logic [Q_W-1:0]   Q_ONE   = 64'h0000_0001_0000_0000;
   localparam logic [Q_W-1:0]   Q_SIX   = 64'h0000_0006_0000_0000;
   localparam logic [OUT_W-1:0] OUT_MAX = '1;

   typedef struct packed {
      logic           sat;
      logic [Q_W-1:0] val;
   } sat64_type;

   typedef struct packed {
      logic             sat;
      logic [OUT_W-1:0] val;
   } sat48_type;

   // Q32.32 product to Q32.32, saturating
   function automatic sat64_type q_sat(input logic [2*Q_W-1:0] p);
      sat64_type r;
      r.sat = |p[127:96];
      r.val = r.sat ? '1 : p[95:32];
      return r;
   endfunction

   // Q32.32 product to Q32.16 in 48 bits, saturating
   function automatic sat48_type q_out(input logic [2*Q_W-1:0] p);
      sat48_type r;
      r.sat = |p[127:96];
      r.val = r.sat ? OUT_MAX : p[95:48];
      return r;
   endfunction

   // Clip a scaled term to 64 bits
   function automatic sat64_type term_sat(input logic [TERM_W-1:0] v);
      sat64_type r;
      r.sat = |v[TERM_W-1:Q_W];
      r.val = r.sat ? '1 : v[Q_W-1:0];
      return r;
   endfunction

   // Saturating 64-bit add
   function automatic sat64_type add_sat(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
      sat64_type      r;
      logic [Q_W:0]   s;
      s     = {1'b0, a} + {1'b0, b};
      r.sat = s[Q_W];
      r.val = s[Q_W] ? '1 : s[Q_W-1:0];
      return r;
   endfunction

endpackage

@@ hdl/rdg0_req_if.sv @@
`timescale 1ns / 1ps
interface rdg0_req_if;
   logic                          valid;
   logic                          ready;
   logic [rdg0_pkg::FIELD_W-1:0]  alpha_total;
   logic [rdg0_pkg::FIELD_W-1:0]  alpha_limit;
   logic [rdg0_pkg::FIELD_W-1:0]  fraction_one;
   logic [rdg0_pkg::FIELD_W-1:0]  fraction_two;
   logic [rdg0_pkg::DIAM_W-1:0]   diameter_one;
   logic [rdg0_pkg::DIAM_W-1:0]   diameter_two;

   modport source (
      output valid, alpha_total, alpha_limit, fraction_one, fraction_two,
             diameter_one, diameter_two,
      input  ready
   );

   modport sink (
      input  valid, alpha_total, alpha_limit, fraction_one, fraction_two,
             diameter_one, diameter_two,
      output ready
   );
endinterface

@@ hdl/rdg0_rsp_if.sv @@
`timescale 1ns / 1ps
interface rdg0_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rdg0_pkg::OUT_W-1:0]  radial_g0;
   logic [rdg0_pkg::OUT_W-1:0]  radial_g0_slope;
   logic                        saturated;

   modport source (
      output valid, radial_g0, radial_g0_slope, saturated,
      input  ready
   );

   modport sink (
      input  valid, radial_g0, radial_g0_slope, saturated,
      output ready
   );
endinterface

@@ hdl/rdg0_div.sv @@
`timescale 1ns / 1ps
module rdg0_div (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [rdg0_pkg::DIV_PAD-1:0]    numer,
   input  logic [rdg0_pkg::FIELD_W-1:0]    denom,
   output logic [rdg0_pkg::DIV_PAD-1:0]    quotient,
   output logic [rdg0_pkg::FIELD_W-1:0]    denom_out
);

   typedef struct packed {
      logic [rdg0_pkg::FIELD_W-1:0] rem;
      logic [rdg0_pkg::DIV_PAD-1:0] nq;
      logic [rdg0_pkg::FIELD_W-1:0] den;
   } div_stage_type;

   div_stage_type stage_ff [rdg0_pkg::DIV_STAGES];
   div_stage_type stage_in [rdg0_pkg::DIV_STAGES];

   // Restoring division: shift dividend bits into the remainder, quotient bits in at bottom
   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type               r;
      logic [rdg0_pkg::FIELD_W:0]  t;
      r = s;
      for (int k = 0; k < rdg0_pkg::DIV_STEP; k++) begin
         t    = {r.rem, r.nq[rdg0_pkg::DIV_PAD-1]};
         r.nq = {r.nq[rdg0_pkg::DIV_PAD-2:0], 1'b0};
         if (t >= {1'b0, r.den}) begin
            r.rem   = rdg0_pkg::FIELD_W'(t - {1'b0, r.den});
            r.nq[0] = 1'b1;
         end else begin
            r.rem = t[rdg0_pkg::FIELD_W-1:0];
         end
      end
      return r;
   endfunction

   // Work out one group of quotient bits per stage
   always_comb begin
      stage_in[0] = div_step('{rem: '0, nq: numer, den: denom});
      for (int s = 1; s < rdg0_pkg::DIV_STAGES; s++) begin
         stage_in[s] = div_step(stage_ff[s-1]);
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign quotient  = stage_ff[rdg0_pkg::DIV_STAGES-1].nq;
   assign denom_out = stage_ff[rdg0_pkg::DIV_STAGES-1].den;

endmodule

@@ hdl/rdg0_qmul.sv @@
`timescale 1ns / 1ps
module rdg0_qmul (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [rdg0_pkg::Q_W-1:0]    mul_a,
   input  logic [rdg0_pkg::Q_W-1:0]    mul_b,
   output logic [2*rdg0_pkg::Q_W-1:0]  product
);

   logic [rdg0_pkg::Q_W-1:0]   part_ff [4];
   logic [rdg0_pkg::Q_W-1:0]   part_in [4];
   logic [2*rdg0_pkg::Q_W-1:0] product_ff;
   logic [2*rdg0_pkg::Q_W-1:0] product_in;

   // 32x32 partial products
   assign part_in[0] = mul_a[31:0]  * mul_b[31:0];
   assign part_in[1] = mul_a[31:0]  * mul_b[63:32];
   assign part_in[2] = mul_a[63:32] * mul_b[31:0];
   assign part_in[3] = mul_a[63:32] * mul_b[63:32];

   // Combine partial products
   assign product_in = {part_ff[3], 64'd0}
                     + {32'd0, part_ff[1], 32'd0}
                     + {32'd0, part_ff[2], 32'd0}
                     + {64'd0, part_ff[0]};

   always_ff @(posedge clock) begin
      if (enable) begin
         part_ff    <= part_in;
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

@@ hdl/radial_distribution_g0.sv @@
`timescale 1ns / 1ps
// The two long divisions, f and then fp = f*2^n/den, run back to back at 4 quotient bits a stage.
// Throughput: one item per cycle; the whole pipeline holds while a result waits on rsp.
// Reset clears all valid bits and sets residual_alpha to 17; data registers are not reset.
module radial_distribution_g0 (
   input  logic                          clock,
   input  logic                          reset,
   rdg0_req_if.sink                      req_if,
   rdg0_rsp_if.source                    rsp_if,
   input  logic                          csr_write_enable,
   input  logic [rdg0_pkg::FIELD_W-1:0]  csr_write_data
);

   localparam int DS   = rdg0_pkg::DIV_STAGES;
   localparam int DP   = rdg0_pkg::DIV_PAD;
   localparam int T0   = 2 + DS;
   localparam int LAT  = T0 + DS + 4;
   localparam int LATE = DS - 8;
   localparam int T2L  = DS - 11;
   localparam int FW   = rdg0_pkg::FIELD_W;
   localparam int DW   = rdg0_pkg::DIAM_W;
   localparam int PW   = rdg0_pkg::PROD_W;
   localparam int NW   = rdg0_pkg::NUM_W;
   localparam int SW   = rdg0_pkg::DSUM_W;
   localparam int RW   = rdg0_pkg::DSR_W;
   localparam int TW   = rdg0_pkg::TERM_W;
   localparam int OW   = rdg0_pkg::OUT_W;

   logic [FW-1:0]  residual_ff;
   logic [LAT-1:0] vld_ff;
   logic           adv;

   // Stage 1
   logic [FW-1:0] res_w, gap_w, den1_in, den1_ff, amax1_ff;
   logic [DW-1:0] d1c_w, d2c_w, d1_1_ff, d2_1_ff;
   logic [PW-1:0] pa_in, pb_in, pa_ff, pb_ff;

   // Stage 2
   logic [PW:0]   sum_w;
   logic [NW-1:0] num2_ff;
   logic [SW-1:0] dsum2_ff;
   logic [RW-1:0] dsr2_ff;
   logic [FW-1:0] den2_ff, amax2_ff;
   logic [DW-1:0] d2_2_ff;

   // Divider outputs
   logic [DP-1:0] qf_w, qx_w, qxp_w, qfp_w;
   logic [FW-1:0] fden_w;
   logic [63:0]   f_t0, x_t0, xp_t0;
   logic          fpsat_w;

   // Products
   logic [127:0] prod_y, prod_v, prod_y2, prod_g, prod_u, prod_t1, prod_t2;

   rdg0_pkg::sat64_type y_ff, v_ff, y2_ff, u_ff;
   rdg0_pkg::sat64_type y_dl_ff [3];
   rdg0_pkg::sat64_type v_dl_ff [8];
   logic [63:0]         f_dl_ff [8];

   rdg0_pkg::sat64_type ty6_ff, ty12_ff, ty16_ff, t8_ff, t24_ff;
   logic                base_ff;

   rdg0_pkg::sat64_type p1a_w, p1_w, p2a_w, p2_w, qf_w2;
   logic [63:0]         p1_ff, p2_ff, qf_ff;
   logic                f0_ff, f1_ff;
   logic [1:0]          fl_dl_ff [2];
   logic [63:0]         p2_dl_ff [LATE];

   rdg0_pkg::sat48_type gq_w, t2q_w, t1q_w;
   rdg0_pkg::sat64_type uq_w;
   rdg0_pkg::sat48_type g0_ff, t2_ff, t1_ff;
   logic                s1u_ff;
   logic                s1_dl_ff [2];
   logic                fps_dl_ff [2];
   rdg0_pkg::sat48_type g0_dl_ff [LATE];
   rdg0_pkg::sat48_type t2_dl_ff [T2L];

   logic [OW:0]   slope_sum_w;
   logic          s1_w;
   logic [OW-1:0] g0_out_ff, slope_out_ff;
   logic          sat_out_ff;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         residual_ff <= rdg0_pkg::RESIDUAL_RESET;
      end else if (csr_write_enable) begin
         residual_ff <= csr_write_data;
      end
   end

   // Advance the pipeline unless the output holds an untaken result
   assign adv          = !vld_ff[LAT-1] || rsp_if.ready;
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_if.valid};
      end
   end

   // Stage 1: free volume, clamped diameters, mixture products
   always_comb begin
      res_w   = (residual_ff == '0) ? FW'(1) : residual_ff;
      gap_w   = req_if.alpha_limit - req_if.alpha_total;
      den1_in = (req_if.alpha_limit > req_if.alpha_total && gap_w > res_w) ? gap_w : res_w;
      d1c_w   = (req_if.diameter_one == '0) ? DW'(1) : req_if.diameter_one;
      d2c_w   = (req_if.diameter_two == '0) ? DW'(1) : req_if.diameter_two;
      pa_in   = PW'(req_if.fraction_one) * PW'(d2c_w);
      pb_in   = PW'(req_if.fraction_two) * PW'(d1c_w);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den1_ff  <= den1_in;
         amax1_ff <= req_if.alpha_limit;
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         d1_1_ff  <= d1c_w;
         d2_1_ff  <= d2c_w;
      end
   end

   // Stage 2: numerator and diameter sum
   assign sum_w = {1'b0, pa_ff} + {1'b0, pb_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         num2_ff  <= NW'(sum_w) << rdg0_pkg::NUM_SH;
         dsr2_ff  <= {1'b0, d1_1_ff} + {1'b0, d2_1_ff};
         dsum2_ff <= SW'({1'b0, d1_1_ff} + {1'b0, d2_1_ff}) << rdg0_pkg::DSUM_SH;
         den2_ff  <= den1_ff;
         amax2_ff <= amax1_ff;
         d2_2_ff  <= d2_1_ff;
      end
   end

   // f, x and xp dividers
   rdg0_div u_div_f (
      .clock     (clock),
      .enable    (adv),
      .numer     (DP'({amax2_ff, 32'd0})),
      .denom     (den2_ff),
      .quotient  (qf_w),
      .denom_out (fden_w)
   );

   rdg0_div u_div_x (
      .clock     (clock),
      .enable    (adv),
      .numer     (DP'(num2_ff)),
      .denom     (FW'(dsum2_ff)),
      .quotient  (qx_w),
      .denom_out ()
   );

   rdg0_div u_div_xp (
      .clock     (clock),
      .enable    (adv),
      .numer     (DP'({d2_2_ff, 30'd0})),
      .denom     (FW'(dsr2_ff)),
      .quotient  (qxp_w),
      .denom_out ()
   );

   assign f_t0  = qf_w[63:0];
   assign x_t0  = qx_w[63:0];
   assign xp_t0 = qxp_w[63:0];

   // fp = f * 2^FRAC_BITS / den
   rdg0_div u_div_fp (
      .clock     (clock),
      .enable    (adv),
      .numer     (DP'({f_t0, {rdg0_pkg::FRAC_BITS{1'b0}}})),
      .denom     (fden_w),
      .quotient  (qfp_w),
      .denom_out ()
   );

   assign fpsat_w = |qfp_w[DP-1:64];

   // y = x*f and v = xp*f
   rdg0_qmul u_mul_y (
      .clock (clock), .enable (adv), .mul_a (x_t0), .mul_b (f_t0), .product (prod_y)
   );

   rdg0_qmul u_mul_v (
      .clock (clock), .enable (adv), .mul_a (xp_t0), .mul_b (f_t0), .product (prod_v)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff <= rdg0_pkg::q_sat(prod_y);
         v_ff <= rdg0_pkg::q_sat(prod_v);
      end
   end

   // y2 = y*y
   rdg0_qmul u_mul_y2 (
      .clock (clock), .enable (adv), .mul_a (y_ff.val), .mul_b (y_ff.val), .product (prod_y2)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         y2_ff <= rdg0_pkg::q_sat(prod_y2);
      end
   end

   // Delay lines for f, y and v
   always_ff @(posedge clock) begin
      if (adv) begin
         f_dl_ff[0] <= f_t0;
         y_dl_ff[0] <= y_ff;
         v_dl_ff[0] <= v_ff;
         for (int i = 1; i < 8; i++) begin
            f_dl_ff[i] <= f_dl_ff[i-1];
            v_dl_ff[i] <= v_dl_ff[i-1];
         end
         for (int i = 1; i < 3; i++) begin
            y_dl_ff[i] <= y_dl_ff[i-1];
         end
      end
   end

   // Polynomial terms: integer multiples of y and y2
   always_ff @(posedge clock) begin
      if (adv) begin
         ty6_ff  <= rdg0_pkg::term_sat(TW'({y_dl_ff[2].val, 2'b0}) + TW'({y_dl_ff[2].val, 1'b0}));
         ty12_ff <= rdg0_pkg::term_sat(TW'({y_dl_ff[2].val, 3'b0}) + TW'({y_dl_ff[2].val, 2'b0}));
         ty16_ff <= rdg0_pkg::term_sat(TW'({y_dl_ff[2].val, 4'b0}));
         t8_ff   <= rdg0_pkg::term_sat(TW'({y2_ff.val, 3'b0}));
         t24_ff  <= rdg0_pkg::term_sat(TW'({y2_ff.val, 4'b0}) + TW'({y2_ff.val, 3'b0}));
         base_ff <= y_dl_ff[2].sat | y2_ff.sat;
      end
   end

   // Polynomial sums
   always_comb begin
      p1a_w = rdg0_pkg::add_sat(rdg0_pkg::Q_ONE, ty6_ff.val);
      p1_w  = rdg0_pkg::add_sat(p1a_w.val, t8_ff.val);
      p2a_w = rdg0_pkg::add_sat(rdg0_pkg::Q_ONE, ty12_ff.val);
      p2_w  = rdg0_pkg::add_sat(p2a_w.val, t24_ff.val);
      qf_w2 = rdg0_pkg::add_sat(rdg0_pkg::Q_SIX, ty16_ff.val);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= p1_w.val;
         p2_ff <= p2_w.val;
         qf_ff <= qf_w2.val;
         f0_ff <= base_ff | ty6_ff.sat | t8_ff.sat | p1a_w.sat | p1_w.sat;
         f1_ff <= base_ff | ty12_ff.sat | t24_ff.sat | ty16_ff.sat
                | p2a_w.sat | p2_w.sat | qf_w2.sat;
      end
   end

   // g0 = f*p1 and u = f*qf
   rdg0_qmul u_mul_g (
      .clock (clock), .enable (adv), .mul_a (f_dl_ff[7]), .mul_b (p1_ff), .product (prod_g)
   );

   rdg0_qmul u_mul_u (
      .clock (clock), .enable (adv), .mul_a (f_dl_ff[7]), .mul_b (qf_ff), .product (prod_u)
   );

   assign gq_w = rdg0_pkg::q_out(prod_g);
   assign uq_w = rdg0_pkg::q_sat(prod_u);

   always_ff @(posedge clock) begin
      if (adv) begin
         fl_dl_ff[0] <= {f0_ff, f1_ff};
         fl_dl_ff[1] <= fl_dl_ff[0];
         g0_ff.sat   <= fl_dl_ff[1][1] | gq_w.sat;
         g0_ff.val   <= (fl_dl_ff[1][1] | gq_w.sat) ? rdg0_pkg::OUT_MAX : gq_w.val;
         u_ff        <= uq_w;
         s1u_ff      <= fl_dl_ff[1][0] | uq_w.sat | v_dl_ff[6].sat;
      end
   end

   // t2 = u*v
   rdg0_qmul u_mul_t2 (
      .clock (clock), .enable (adv), .mul_a (u_ff.val), .mul_b (v_dl_ff[7].val),
      .product (prod_t2)
   );

   assign t2q_w = rdg0_pkg::q_out(prod_t2);

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_dl_ff[0] <= s1u_ff;
         s1_dl_ff[1] <= s1_dl_ff[0];
         t2_ff.val   <= t2q_w.val;
         t2_ff.sat   <= s1_dl_ff[1] | t2q_w.sat;
      end
   end

   // Hold p2, g0 and t2 until fp arrives
   always_ff @(posedge clock) begin
      if (adv) begin
         p2_dl_ff[0] <= p2_ff;
         g0_dl_ff[0] <= g0_ff;
         for (int i = 1; i < LATE; i++) begin
            p2_dl_ff[i] <= p2_dl_ff[i-1];
            g0_dl_ff[i] <= g0_dl_ff[i-1];
         end
         t2_dl_ff[0] <= t2_ff;
         for (int i = 1; i < T2L; i++) begin
            t2_dl_ff[i] <= t2_dl_ff[i-1];
         end
      end
   end

   // t1 = fp*p2
   rdg0_qmul u_mul_t1 (
      .clock (clock), .enable (adv), .mul_a (qfp_w[63:0]), .mul_b (p2_dl_ff[LATE-1]),
      .product (prod_t1)
   );

   assign t1q_w = rdg0_pkg::q_out(prod_t1);

   always_ff @(posedge clock) begin
      if (adv) begin
         fps_dl_ff[0] <= fpsat_w;
         fps_dl_ff[1] <= fps_dl_ff[0];
         t1_ff.val    <= t1q_w.val;
         t1_ff.sat    <= fps_dl_ff[1] | t1q_w.sat;
      end
   end

   // Output stage: slope sum and result register
   assign slope_sum_w = {1'b0, t1_ff.val} + {1'b0, t2_dl_ff[T2L-1].val};
   assign s1_w        = t1_ff.sat | t2_dl_ff[T2L-1].sat | slope_sum_w[OW];

   always_ff @(posedge clock) begin
      if (adv) begin
         g0_out_ff    <= g0_dl_ff[LATE-1].val;
         slope_out_ff <= s1_w ? rdg0_pkg::OUT_MAX : slope_sum_w[OW-1:0];
         sat_out_ff   <= g0_dl_ff[LATE-1].sat | s1_w;
      end
   end

   assign rsp_if.valid           = vld_ff[LAT-1];
   assign rsp_if.radial_g0       = g0_out_ff;
   assign rsp_if.radial_g0_slope = slope_out_ff;
   assign rsp_if.saturated       = sat_out_ff;

   // A held pipeline keeps its valid bits
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid bits moved during a hold");

   // An accepted transfer enters stage one
   a_enter: assert property (@(posedge clock) disable iff (reset)
      adv && req_if.valid |=> vld_ff[0])
      else $error("accepted transfer lost at entry");

   // A clipped g0 shows up clipped and flagged
   a_g0_clip: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[LAT-2] && g0_dl_ff[LATE-1].sat |=>
         rsp_if.valid && rsp_if.radial_g0 == rdg0_pkg::OUT_MAX && rsp_if.saturated)
      else $error("g0 saturation not reflected at output");

   // A clipped slope term forces the slope to its maximum
   a_slope_clip: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[LAT-2] && t1_ff.sat |=>
         rsp_if.radial_g0_slope == rdg0_pkg::OUT_MAX && rsp_if.saturated)
      else $error("slope saturation not reflected at output");

endmodule
